// ===== hw/rtl/ackt_pkg.sv =====
// Shared types, codes and constants for the acknowledge/retransmit tracker.
// Used by ackt_ack_asm, ack_retransmit_tracker, ackt_scoreboard and the testbench; depends on nothing.
`default_nettype none

package ackt_pkg;

  localparam int SLOTS_DEF       = 32;
  localparam int PAYLOAD_MAX_DEF = 128;

  localparam int ID_W   = 32;
  localparam int LEN_W  = 8;
  localparam int TMR_W  = 16;
  localparam int EV_W   = 3;
  localparam int SLOT_W = 6;
  localparam int ACT_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 3;
  localparam int GRP_W  = 40;

  localparam logic [BYTE_W-1:0] ACK_LEAD        = 8'h06;
  localparam logic [CNT_W-1:0]  ACK_GROUP       = 3'd5;
  localparam logic [TMR_W-1:0]  FIRST_WAIT_RST  = 16'd3000;
  localparam logic [TMR_W-1:0]  SECOND_WAIT_RST = 16'd5000;

  typedef enum logic [ACT_W-1:0] {
    ACT_NEW  = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [EV_W-1:0] {
    EV_SENT    = 3'd0,
    EV_RETRY   = 3'd1,
    EV_DROPPED = 3'd2,
    EV_ACKED   = 3'd3,
    EV_UNKNOWN = 3'd4,
    EV_BAD     = 3'd5,
    EV_FULL    = 3'd6
  } event_t;

  typedef enum logic [0:0] {
    REG_FIRST_WAIT  = 1'b0,
    REG_SECOND_WAIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_ACK_CMP,
    ST_TICK_RD,
    ST_TICK_PROC,
    ST_FLUSH
  } state_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [TMR_W-1:0] timer;
    logic             retried;
  } rec_t;

  // One result beat without its last flag.
  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } res_t;

  // Status of the acknowledge byte gatherer for the current byte.
  typedef struct packed {
    logic            done;
    logic            lead_ok;
    logic [ID_W-1:0] id;
  } ack_grp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ackt_ack_asm.sv =====
// Gathers acknowledge bytes into groups of five: lead byte plus a 32-bit id, LSB first.
// Depends on ackt_pkg.
`default_nettype none

module ackt_ack_asm import ackt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output ack_grp_t               grp
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [GRP_W-1:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] filled;

  always_comb begin
    pos       = (count_r < ACK_GROUP) ? count_r : '0;
    filled    = pos + 1'b1;
    bytes_nxt = bytes_r;
    bytes_nxt[BYTE_W*pos +: BYTE_W] = rx_byte;
    count_nxt = (filled >= ACK_GROUP) ? '0 : filled;
  end

  // The group view includes the byte of this beat.
  assign grp = '{done:    byte_en && (filled >= ACK_GROUP),
                 lead_ok: (bytes_nxt[BYTE_W-1:0] == ACK_LEAD),
                 id:      bytes_nxt[BYTE_W +: ID_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bytes_r <= '0;
    end else if (byte_en) begin
      count_r <= count_nxt;
      bytes_r <= bytes_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ack_retransmit_tracker.sv =====
// Acknowledge/retransmit tracker: a new message passes through the flush state; an acknowledge
// byte that completes a group with a good lead byte starts a scan that reads, then compares
// each busy slot; a tick scans likewise, with a timer read-modify-write per busy slot.
// One item at a time; out_stall can hold a flush or a timer expiry. Synchronous reset:
// all slots free, next id 0, first_wait 3000, second_wait 5000, no beat pending. No clearing
// pass is needed. Depends on ackt_pkg and ackt_ack_asm.
`default_nettype none

module ack_retransmit_tracker import ackt_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [LEN_W-1:0]  in_payload_len,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  // Result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [EV_W-1:0]        out_event_res,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [ID_W-1:0]        out_message_id,
  output logic [LEN_W-1:0]       out_message_len,
  output logic                   out_last,
  // Configuration port
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [TMR_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_MAX);

  // Control state. Slot busy flags are flip-flops so reset frees every slot at once;
  // the rest of each slot record lives in the slot memory below.
  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   busy_r, busy_nxt;
  logic [ID_W-1:0]    next_id_r, next_id_nxt;
  logic [TMR_W-1:0]   first_wait_r, second_wait_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [ID_W-1:0]    key_id_r, key_id_nxt;

  // One result is held back in the pending register until the scan knows whether
  // another follows, so the last flag can be set on the final beat of the item.
  logic               pend_valid_r, pend_valid_nxt;
  res_t               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;
  logic               out_last_r, out_last_nxt;

  // Slot memory: one write port, one registered read port.
  rec_t               mem [SLOTS];
  rec_t               rd_q;
  logic               rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  rec_t               mem_wd;

  logic               in_accept;
  logic               out_free;
  logic [LEN_W-1:0]   plen_sat;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               is_last;
  logic               id_hit;
  logic               tmr_expire;
  logic               tick_hold;
  ack_grp_t           grp;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign plen_sat  = (in_payload_len > LEN_MAX) ? LEN_MAX : in_payload_len;
  assign is_last    = (idx_r == IDX_LAST);
  assign id_hit     = (rd_q.id == key_id_r);
  assign tmr_expire = (rd_q.timer < TMR_W'(2));
  // A timer expiry must move the older pending result out first; wait for room.
  assign tick_hold  = tmr_expire && pend_valid_r && !out_free;

  ackt_ack_asm u_ack_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_accept && (in_action == ACT_ACK)),
    .rx_byte (in_rx_byte),
    .grp     (grp)
  );

  // Lowest free slot from the busy flags.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_action)
            ACT_NEW:  state_nxt = ST_FLUSH;
            ACT_ACK: begin
              if (grp.done) begin
                state_nxt = grp.lead_ok ? ST_ACK_RD : ST_FLUSH;
              end
            end
            ACT_TICK: state_nxt = ST_TICK_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACK_RD: begin
        if (busy_r[idx_r]) begin
          state_nxt = ST_ACK_CMP;
        end else if (is_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_ACK_CMP: begin
        state_nxt = (id_hit || is_last) ? ST_FLUSH : ST_ACK_RD;
      end
      ST_TICK_RD: begin
        if (busy_r[idx_r]) begin
          state_nxt = ST_TICK_PROC;
        end else if (is_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_TICK_PROC: begin
        if (!tick_hold) begin
          state_nxt = is_last ? ST_FLUSH : ST_TICK_RD;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    busy_nxt       = busy_r;
    next_id_nxt    = next_id_r;
    idx_nxt        = idx_r;
    key_id_nxt     = key_id_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = rd_q;

    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          idx_nxt = '0;
          case (in_action)
            ACT_NEW: begin
              pend_valid_nxt = 1'b1;
              if (free_found) begin
                busy_nxt[free_idx] = 1'b1;
                mem_we         = 1'b1;
                mem_wa         = free_idx;
                mem_wd.id      = next_id_r;
                mem_wd.len     = plen_sat;
                mem_wd.timer   = first_wait_r;
                mem_wd.retried = 1'b0;
                next_id_nxt    = next_id_r + 1'b1;
                pend_nxt = '{ev: EV_SENT, slot: SLOT_W'(free_idx), id: next_id_r, len: plen_sat};
              end else begin
                pend_nxt = '{ev: EV_FULL, slot: '0, id: next_id_r, len: plen_sat};
              end
            end
            ACT_ACK: begin
              if (grp.done) begin
                key_id_nxt = grp.id;
                if (!grp.lead_ok) begin
                  pend_valid_nxt = 1'b1;
                  pend_nxt = '{ev: EV_BAD, slot: '0, id: grp.id, len: '0};
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACK_RD: begin
        if (busy_r[idx_r]) begin
          rd_en = 1'b1;
        end else if (is_last) begin
          pend_valid_nxt = 1'b1;
          pend_nxt = '{ev: EV_UNKNOWN, slot: '0, id: key_id_r, len: '0};
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_ACK_CMP: begin
        if (id_hit) begin
          busy_nxt[idx_r] = 1'b0;
          pend_valid_nxt  = 1'b1;
          pend_nxt = '{ev: EV_ACKED, slot: SLOT_W'(idx_r), id: key_id_r, len: rd_q.len};
        end else if (is_last) begin
          pend_valid_nxt = 1'b1;
          pend_nxt = '{ev: EV_UNKNOWN, slot: '0, id: key_id_r, len: '0};
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TICK_RD: begin
        if (busy_r[idx_r]) begin
          rd_en = 1'b1;
        end else if (!is_last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TICK_PROC: begin
        if (!tick_hold) begin
          mem_we = 1'b1;
          if (!tmr_expire) begin
            mem_wd.timer = rd_q.timer - 1'b1;
          end else begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            if (!rd_q.retried) begin
              mem_wd.retried = 1'b1;
              mem_wd.timer   = second_wait_r;
              pend_nxt = '{ev: EV_RETRY, slot: SLOT_W'(idx_r), id: rd_q.id, len: rd_q.len};
            end else begin
              busy_nxt[idx_r] = 1'b0;
              mem_wd.timer    = '0;
              pend_nxt = '{ev: EV_DROPPED, slot: SLOT_W'(idx_r), id: rd_q.id, len: rd_q.len};
            end
          end
          if (!is_last) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Reads and writes of the same slot never overlap: in a tick scan each busy slot is read, then
  // written back in ST_TICK_PROC before the scan moves on to the next slot.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      busy_r        <= '0;
      next_id_r     <= '0;
      idx_r         <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      first_wait_r  <= FIRST_WAIT_RST;
      second_wait_r <= SECOND_WAIT_RST;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      next_id_r    <= next_id_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_WAIT:  first_wait_r  <= cfg_wdata;
          REG_SECOND_WAIT: second_wait_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_id_r   <= key_id_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_r.ev;
  assign out_slot        = out_r.slot;
  assign out_message_id  = out_r.id;
  assign out_message_len = out_r.len;
  assign out_last        = out_last_r;

  // Every item has delivered its held-back result before a new item is taken.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("pending result left over in idle");

  // A matched acknowledge frees its slot.
  a_ack_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACK_CMP && id_hit) |=> !busy_r[$past(idx_r)])
    else $error("acknowledged slot still busy");

  // A new message with a free slot claims it.
  a_new_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_action == ACT_NEW && free_found) |=> busy_r[$past(free_idx)])
    else $error("new message did not claim its slot");

endmodule

`default_nettype wire

// ===== verif/ackt_scoreboard.sv =====
// Checker for the acknowledge/retransmit tracker: watches the input, result and register ports,
// predicts every result beat and compares it with what the block delivers.
// Depends on ackt_pkg.
`default_nettype none

module ackt_scoreboard import ackt_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [LEN_W-1:0]  in_payload_len,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [EV_W-1:0]   out_event_res,
  input  wire logic [SLOT_W-1:0] out_slot,
  input  wire logic [ID_W-1:0]   out_message_id,
  input  wire logic [LEN_W-1:0]  out_message_len,
  input  wire logic              out_last,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [TMR_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    event_t            ev;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic              last;
  } beat_t;

  beat_t             expected_beats[$];
  logic [TMR_W-1:0]  wait_first, wait_second;
  logic              busy[SLOTS];
  logic [ID_W-1:0]   rec_id[SLOTS];
  logic [LEN_W-1:0]  rec_len[SLOTS];
  logic [TMR_W-1:0]  rec_timer[SLOTS];
  logic              rec_retried[SLOTS];
  logic [ID_W-1:0]   id_next;
  int                grp_count;
  logic [BYTE_W-1:0] grp_bytes[5];

  task automatic push_beat(event_t ev, int sl, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
    beat_t b;
    b.ev = ev; b.slot = sl[SLOT_W-1:0]; b.id = id; b.len = len; b.last = 1'b0;
    expected_beats.push_back(b);
  endtask

  // Works out the beats one accepted input item causes and updates the shadow table.
  task automatic track_item(logic [ACT_W-1:0] act, logic [LEN_W-1:0] plen, logic [BYTE_W-1:0] rxb);
    int n_prior;
    int hit;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0] id;
    n_prior = expected_beats.size();
    hit = -1;
    case (act)
      ACT_NEW: begin
        len = (plen > PAYLOAD_MAX) ? LEN_W'(PAYLOAD_MAX) : plen;
        for (int i = SLOTS - 1; i >= 0; i--) if (!busy[i]) hit = i;
        if (hit < 0) begin
          push_beat(EV_FULL, 0, id_next, len);
        end else begin
          busy[hit] = 1'b1; rec_id[hit] = id_next; rec_len[hit] = len;
          rec_timer[hit] = wait_first; rec_retried[hit] = 1'b0;
          push_beat(EV_SENT, hit, id_next, len);
          id_next = id_next + 1;
        end
      end
      ACT_ACK: begin
        grp_bytes[grp_count] = rxb;
        grp_count++;
        if (grp_count == 5) begin
          grp_count = 0;
          id = {grp_bytes[4], grp_bytes[3], grp_bytes[2], grp_bytes[1]};
          if (grp_bytes[0] != ACK_LEAD) begin
            push_beat(EV_BAD, 0, id, '0);
          end else begin
            for (int i = SLOTS - 1; i >= 0; i--) if (busy[i] && rec_id[i] == id) hit = i;
            if (hit < 0) begin
              push_beat(EV_UNKNOWN, 0, id, '0);
            end else begin
              busy[hit] = 1'b0;
              push_beat(EV_ACKED, hit, id, rec_len[hit]);
            end
          end
        end
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!busy[i]) continue;
          if (rec_timer[i] > 1) begin
            rec_timer[i]--;
          end else if (!rec_retried[i]) begin
            rec_retried[i] = 1'b1; rec_timer[i] = wait_second;
            push_beat(EV_RETRY, i, rec_id[i], rec_len[i]);
          end else begin
            busy[i] = 1'b0; rec_timer[i] = '0;
            push_beat(EV_DROPPED, i, rec_id[i], rec_len[i]);
          end
        end
      end
      default: ;
    endcase
    if (expected_beats.size() > n_prior) expected_beats[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (!rst_n) begin
      expected_beats.delete();
      wait_first = FIRST_WAIT_RST; wait_second = SECOND_WAIT_RST;
      for (int i = 0; i < SLOTS; i++) busy[i] = 1'b0;
      id_next = '0; grp_count = 0;
      fail_count = 0; beats_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FIRST_WAIT) wait_first = cfg_wdata;
        else wait_second = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat ev=%0d slot=%0d id=%h len=%0d last=%0b",
                   $time, out_event_res, out_slot, out_message_id, out_message_len, out_last);
        end else begin
          e = expected_beats.pop_front();
          if (out_event_res !== e.ev || out_slot !== e.slot || out_message_id !== e.id ||
              out_message_len !== e.len || out_last !== e.last) begin
            fail_count++;
            $display("%0t: mismatch expected ev=%0d slot=%0d id=%h len=%0d last=%0b",
                     $time, e.ev, e.slot, e.id, e.len, e.last);
            $display("%0t:          actual   ev=%0d slot=%0d id=%h len=%0d last=%0b",
                     $time, out_event_res, out_slot, out_message_id, out_message_len, out_last);
          end
        end
      end
      if (in_valid && !in_stall) track_item(in_action, in_payload_len, in_rx_byte);
    end
    pending = expected_beats.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_ack_retransmit_tracker.sv =====
// Top of the tracker testbench: clock, reset, stimulus and the verdict.
// Depends on ackt_pkg, ack_retransmit_tracker and ackt_scoreboard.
`default_nettype none

module tb_ack_retransmit_tracker;
  import ackt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  // Settling time after the last expected beat, with margin for the longest internal scan.
  localparam int SETTLE_CYCLES = 150;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action = ACT_NONE;
  logic [LEN_W-1:0]  in_payload_len = '0;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [EV_W-1:0]   out_event_res;
  logic [SLOT_W-1:0] out_slot;
  logic [ID_W-1:0]   out_message_id;
  logic [LEN_W-1:0]  out_message_len;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = REG_FIRST_WAIT;
  logic [TMR_W-1:0]  cfg_wdata = '0;

  int fail_count, pending, beats_seen;
  int send_idle_pct = 0;   // chance in percent of an idle step before each beat offered
  int recv_stall_pct = 0;  // chance in percent that the receiver stalls, drawn anew at each falling edge
  int cycles = 0;
  int items_sent = 0;
  // Count of new-message items sent; a good guess of the next id to acknowledge.
  int news_sent = 0;

  ack_retransmit_tracker dut (.*);

  ackt_scoreboard checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle limit: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls at random; one assignment per falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Offers one beat on the input channel and waits until the block takes it.
  task automatic send(logic [ACT_W-1:0] act, logic [LEN_W-1:0] plen, logic [BYTE_W-1:0] rxb);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_payload_len <= plen;
    in_rx_byte <= rxb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act == ACT_NEW) news_sent++;
  endtask

  // A complete acknowledge group: lead byte followed by the id, low byte first.
  task automatic send_ack(logic [BYTE_W-1:0] lead, logic [ID_W-1:0] id);
    send(ACT_ACK, $urandom, lead);
    for (int k = 0; k < 4; k++) send(ACT_ACK, $urandom, id[8*k +: 8]);
  endtask

  // Registers may only change while the block is idle, so let every pending beat drain first.
  task automatic write_waits(logic [TMR_W-1:0] first, logic [TMR_W-1:0] second);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_FIRST_WAIT; cfg_wdata <= first;
    @(negedge clk);
    cfg_index <= REG_SECOND_WAIT; cfg_wdata <= second;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic: new messages, acknowledges mostly of recent ids, ticks, unused actions
  // and some stray bytes that break up groups.
  task automatic random_traffic(int count, bit fill_burst);
    int pick;
    logic [ID_W-1:0] id;
    if (fill_burst) repeat (34) send(ACT_NEW, $urandom_range(128), $urandom);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 32) begin
        send(ACT_NEW, ($urandom_range(9) == 0) ? $urandom : $urandom_range(128), $urandom);
      end else if (pick < 60) begin
        id = news_sent - 1 - $urandom_range(news_sent > 40 ? 40 : news_sent);
        if ($urandom_range(9) == 0) id = $urandom;
        send_ack(($urandom_range(9) == 0) ? $urandom : ACK_LEAD, id);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send(ACT_TICK, $urandom, $urandom);
      end else if (pick < 95) begin
        send(ACT_ACK, $urandom, $urandom);
      end else begin
        send(ACT_NONE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling, one-tick waits so expiries come at once.
    write_waits(16'd1, 16'd1);
    send(ACT_NEW, 8'd0, 8'h00);           // shortest payload, slot 0
    send(ACT_NEW, 8'd128, 8'hff);         // longest legal payload
    send(ACT_NEW, 8'd255, 8'h00);         // saturated to the maximum
    send_ack(ACK_LEAD, 32'd1);            // acknowledges the middle slot
    send_ack(8'hf9, 32'hffff_ffff);       // bad lead byte
    send_ack(ACK_LEAD, 32'h8000_0000);    // unknown id
    send(ACT_ACK, 8'h00, ACK_LEAD);       // partial group, no result yet
    send(ACT_NONE, 8'hff, 8'hff);         // unused action is ignored
    send(ACT_TICK, 8'h00, 8'h00);         // both remaining slots retry
    send(ACT_TICK, 8'h00, 8'h00);         // and are dropped
    send(ACT_TICK, 8'h00, 8'h00);         // nothing left to expire
    send(ACT_ACK, 8'h00, 8'h00);          // finishes the partial group as unknown
    send(ACT_ACK, 8'h00, 8'h00);
    send(ACT_ACK, 8'h00, 8'h00);
    send(ACT_ACK, 8'h00, 8'h00);

    // Zero first wait behaves like one; long second wait never drops.
    write_waits(16'd0, 16'hffff);
    send_idle_pct = 86; recv_stall_pct = 0;
    random_traffic(20, 1'b0);

    write_waits(16'd3, 16'd5);
    send_idle_pct = 0; recv_stall_pct = 86;
    random_traffic(20, 1'b0);

    // Longest first wait: slots pile up and the table overflows.
    write_waits(16'hffff, 16'd0);
    send_idle_pct = 22; recv_stall_pct = 22;
    random_traffic(20, 1'b1);

    write_waits(16'd2, 16'd4);
    send_idle_pct = 0; recv_stall_pct = 0;
    random_traffic(20, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input beats and %0d result beats over five wait settings,",
             items_sent, beats_seen);
    $display("including table overflow, bad and unknown acknowledges, retries and drops.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
